FILE: rtl/nirp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_pkg
// shared types, codes and helpers of the infrared pulse decoder
// ----------------------------------------------------------------------------
package nirp_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned TDATA_IN_W = 16;
  localparam int unsigned TUSER_IN_W = 2;
  localparam int unsigned TDATA_OUT_W = 24;

  localparam logic [3:0] TIMEOUT_TICKS = 4'd14;

  // event codes
  localparam logic [1:0] CMD_RISE = 2'd0;
  localparam logic [1:0] CMD_FALL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_SCAN = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ZERO_WIN   = 3'd0;
  localparam logic [2:0] REG_ONE_WIN    = 3'd1;
  localparam logic [2:0] REG_REPEAT_WIN = 3'd2;
  localparam logic [2:0] REG_HEADER_WIN = 3'd3;
  localparam logic [2:0] REG_REMOTE     = 3'd4;

  typedef struct packed {
    logic [31:0] zero_window;
    logic [31:0] one_window;
    logic [31:0] repeat_window;
    logic [31:0] header_window;
    logic [7:0]  remote_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pulse_width;
  } item_t;

  typedef struct packed {
    logic [7:0] repeat_total;
    logic       frame_active;
    logic       frame_ready;
    logic [7:0] key_code;
  } result_t;

  // strict window: min < width < max
  function automatic logic in_window(input logic [31:0] win, input logic [15:0] w);
    in_window = (w > win[15:0]) && (w < win[31:16]);
  endfunction

endpackage

FILE: rtl/nirp_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_apb_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module nirp_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nirp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output nirp_pkg::cfg_t                cfg_o
);
  import nirp_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_window    <= 32'd52429100;
      cfg_q.one_window     <= 32'd117966200;
      cfg_q.repeat_window  <= 32'd170395800;
      cfg_q.header_window  <= 32'd308023400;
      cfg_q.remote_address <= 8'd0;
    end else if (wr_en) begin
      case (idx)
        REG_ZERO_WIN:   cfg_q.zero_window    <= pwdata;
        REG_ONE_WIN:    cfg_q.one_window     <= pwdata;
        REG_REPEAT_WIN: cfg_q.repeat_window  <= pwdata;
        REG_HEADER_WIN: cfg_q.header_window  <= pwdata;
        REG_REMOTE:     cfg_q.remote_address <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_WIN:   prdata = cfg_q.zero_window;
      REG_ONE_WIN:    prdata = cfg_q.one_window;
      REG_REPEAT_WIN: prdata = cfg_q.repeat_window;
      REG_HEADER_WIN: prdata = cfg_q.header_window;
      REG_REMOTE:     prdata = {24'd0, cfg_q.remote_address};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/nirp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_in_stage
// input register for one event word
// ----------------------------------------------------------------------------
module nirp_in_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [nirp_pkg::TDATA_IN_W-1:0]  s_data_i,
  input  logic [nirp_pkg::TUSER_IN_W-1:0]  s_user_i,
  input  logic                             take_i,
  output logic                             valid_o,
  output nirp_pkg::item_t                  item_o
);
  import nirp_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign s_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q.cmd         <= s_user_i;
      item_q.pulse_width <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/nirp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_core
// frame state and combinational event handling
// ----------------------------------------------------------------------------
module nirp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  nirp_pkg::item_t   item_i,
  input  nirp_pkg::cfg_t    cfg_i,
  output nirp_pkg::result_t result_o
);
  import nirp_pkg::*;

  logic        hs_q, hs_d;
  logic        rf_q, rf_d;
  logic        hc_q, hc_d;
  logic [3:0]  ot_q, ot_d;
  logic [31:0] cs_q, cs_d;
  logic [7:0]  rc_q, rc_d;
  logic [7:0]  key;
  logic        addr_ok;
  logic        cmd_ok;

  assign addr_ok = (cs_q[7:0] == ~cs_q[15:8]) && (cs_q[7:0] == cfg_i.remote_address);
  assign cmd_ok  = (cs_q[23:16] == ~cs_q[31:24]);

  always_comb begin
    hs_d = hs_q;
    rf_d = rf_q;
    hc_d = hc_q;
    ot_d = ot_q;
    cs_d = cs_q;
    rc_d = rc_q;
    key  = 8'd0;
    case (item_i.cmd)
      CMD_RISE: begin
        hc_d = 1'b1;
      end
      CMD_FALL: begin
        if (hc_q) begin
          if (hs_q) begin
            if (in_window(cfg_i.zero_window, item_i.pulse_width)) begin
              cs_d = {1'b0, cs_q[31:1]};
            end else if (in_window(cfg_i.one_window, item_i.pulse_width)) begin
              cs_d = {1'b1, cs_q[31:1]};
            end else if (in_window(cfg_i.repeat_window, item_i.pulse_width)) begin
              rc_d = rc_q + 8'd1;
              ot_d = 4'd0;
            end
          end else if (in_window(cfg_i.header_window, item_i.pulse_width)) begin
            hs_d = 1'b1;
            rc_d = 8'd0;
          end
        end
        hc_d = 1'b0;
      end
      CMD_TICK: begin
        if (hs_q) begin
          hc_d = 1'b0;
          if (ot_q == 4'd0) begin
            rf_d = 1'b1;
          end
          if (ot_q < TIMEOUT_TICKS) begin
            ot_d = ot_q + 4'd1;
          end else begin
            hs_d = 1'b0;
            ot_d = 4'd0;
          end
        end
      end
      CMD_SCAN: begin
        if (rf_q) begin
          if (addr_ok && cmd_ok) begin
            key = cs_q[23:16];
          end
          if (key == 8'd0 || !hs_q) begin
            rf_d = 1'b0;
            rc_d = 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= 1'b0;
      rf_q <= 1'b0;
      hc_q <= 1'b0;
      ot_q <= 4'd0;
      cs_q <= 32'd0;
      rc_q <= 8'd0;
    end else if (step_i) begin
      hs_q <= hs_d;
      rf_q <= rf_d;
      hc_q <= hc_d;
      ot_q <= ot_d;
      cs_q <= cs_d;
      rc_q <= rc_d;
    end
  end

  assign result_o.key_code     = key;
  assign result_o.frame_ready  = rf_d;
  assign result_o.frame_active = hs_d;
  assign result_o.repeat_total = rc_d;

endmodule

FILE: rtl/nirp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_out_stage
// result register toward the downstream stream
// ----------------------------------------------------------------------------
module nirp_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  nirp_pkg::result_t                 result_i,
  output logic                              ready_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [nirp_pkg::TDATA_OUT_W-1:0]  m_data_o
);
  import nirp_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {6'd0, result_q};

endmodule

FILE: rtl/nec_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder
// nec infrared receiver decoder, one channel
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one event word: tuser = event kind (rise, fall,
//   tick, scan), tdata = measured high width. master stream returns one
//   status word per event: decoded key, frame ready, frame active and the
//   repeat count. the window and address registers sit on the apb port;
//   the user must write them only while the stream is idle, and
//   the block itself does not enforce this. an accepted word passes the
//   input register, then event handling into the result register.
//   throughput is one word per cycle while the receiver takes every word.
//   when the receiver stalls, the result register holds its word and the
//   input register keeps one more; s_axis_tready drops once both are full.
//   reset clears the frame state, both valid flags and loads the default
//   windows with a zero remote address.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [nirp_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // pulse_width
  input  logic [nirp_pkg::TUSER_IN_W-1:0]   s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // key_code[7:0], frame_ready[8], frame_active[9], repeat_total[17:10], zero pad
  output logic [nirp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nirp_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import nirp_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    in_valid;
  logic    out_ready;
  logic    step;

  assign step = in_valid & out_ready;

  nirp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nirp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .take_i    (step),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  nirp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  nirp_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .result_i  (result),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/nirp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
module nirp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [nirp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);

  // no output word while in reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // with an empty result register the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a returned key keeps ready only while the frame is still active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> (m_axis_tdata[8] == m_axis_tdata[9]))
    else $error("key returned with inconsistent frame flags");

endmodule

bind nec_ir_pulse_decoder nirp_checker u_nirp_checker (.*);

FILE: test/nirp_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirp_decode_checker
// watches the event and status streams of the infrared pulse decoder, keeps
// its own copy of the frame state and the window registers, predicts one
// status word per accepted event and compares every returned word in order
// ----------------------------------------------------------------------------
module nirp_decode_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [nirp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // pulse_width
  input  logic [nirp_pkg::TUSER_IN_W-1:0]  s_axis_tuser,  // cmd
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // key_code[7:0], frame_ready[8], frame_active[9], repeat_total[17:10], zero pad
  input  logic [nirp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nirp_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);
  import nirp_pkg::*;

  localparam logic [31:0] ZERO_WIN_RST   = 32'd52429100;
  localparam logic [31:0] ONE_WIN_RST    = 32'd117966200;
  localparam logic [31:0] REPEAT_WIN_RST = 32'd170395800;
  localparam logic [31:0] HEADER_WIN_RST = 32'd308023400;
  localparam int unsigned STATUS_W = $bits(result_t);

  logic [31:0] zero_win, one_win, rep_win, hdr_win;
  logic [7:0]  remote_addr;

  logic        hdr_seen, rdy, high_cap;
  logic [3:0]  ovf_ticks;
  logic [31:0] code_reg;
  logic [7:0]  rep_cnt;

  result_t     pending_status[$];
  result_t     want;
  int unsigned fails;

  function automatic logic width_fits(input logic [31:0] win, input logic [15:0] width);
    logic [15:0] lo, hi;
    lo = win[15:0];
    hi = win[31:16];
    return (lo < width) && (width < hi);
  endfunction

  function automatic result_t decode_event(input logic [1:0] cmd, input logic [15:0] width);
    result_t st;
    logic [7:0] key;
    key = 8'd0;
    case (cmd)
      CMD_RISE: begin
        high_cap = 1'b1;
      end
      CMD_FALL: begin
        if (high_cap) begin
          if (hdr_seen) begin
            if (width_fits(zero_win, width)) begin
              code_reg = {1'b0, code_reg[31:1]};
            end else if (width_fits(one_win, width)) begin
              code_reg = {1'b1, code_reg[31:1]};
            end else if (width_fits(rep_win, width)) begin
              rep_cnt   = rep_cnt + 8'd1;
              ovf_ticks = 4'd0;
            end
          end else if (width_fits(hdr_win, width)) begin
            hdr_seen = 1'b1;
            rep_cnt  = 8'd0;
          end
        end
        high_cap = 1'b0;
      end
      CMD_TICK: begin
        if (hdr_seen) begin
          high_cap = 1'b0;
          if (ovf_ticks == 4'd0) rdy = 1'b1;
          if (ovf_ticks < TIMEOUT_TICKS) begin
            ovf_ticks = ovf_ticks + 4'd1;
          end else begin
            hdr_seen  = 1'b0;
            ovf_ticks = 4'd0;
          end
        end
      end
      default: begin
        if (rdy) begin
          if (code_reg[7:0] == ~code_reg[15:8] && code_reg[7:0] == remote_addr &&
              code_reg[23:16] == ~code_reg[31:24]) begin
            key = code_reg[23:16];
          end
          if (key == 8'd0 || !hdr_seen) begin
            rdy     = 1'b0;
            rep_cnt = 8'd0;
          end
        end
      end
    endcase
    st.key_code     = key;
    st.frame_ready  = rdy;
    st.frame_active = hdr_seen;
    st.repeat_total = rep_cnt;
    return st;
  endfunction

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_win     = ZERO_WIN_RST;
      one_win      = ONE_WIN_RST;
      rep_win      = REPEAT_WIN_RST;
      hdr_win      = HEADER_WIN_RST;
      remote_addr  = 8'd0;
      hdr_seen     = 1'b0;
      rdy          = 1'b0;
      high_cap     = 1'b0;
      ovf_ticks    = 4'd0;
      code_reg     = 32'd0;
      rep_cnt      = 8'd0;
      fails        = 0;
      pending_status.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ZERO_WIN:   zero_win    = pwdata;
          REG_ONE_WIN:    one_win     = pwdata;
          REG_REPEAT_WIN: rep_win     = pwdata;
          REG_HEADER_WIN: hdr_win     = pwdata;
          REG_REMOTE:     remote_addr = pwdata[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: no status word expected, got %h", $time, m_axis_tdata);
          fails++;
        end else begin
          want = pending_status.pop_front();
          check_field("key_code", want.key_code, m_axis_tdata[7:0]);
          check_field("frame_ready", want.frame_ready, m_axis_tdata[8]);
          check_field("frame_active", want.frame_active, m_axis_tdata[9]);
          check_field("repeat_total", want.repeat_total, m_axis_tdata[17:10]);
          check_field("pad", 0, m_axis_tdata[TDATA_OUT_W-1:STATUS_W]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_status.push_back(decode_event(s_axis_tuser, s_axis_tdata));
      end
      fail_count_o <= fails;
      pending_o    <= pending_status.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the infrared pulse decoder: a directed pass over the edge,
// window and scan corner cases at reset settings, then several register
// settings with random nec frames, repeats, timeouts and noise, random stalls
// on both streams and one long receiver hold-off; the checker gives the verdict
// ----------------------------------------------------------------------------
module tb;
  import nirp_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // pulse_width
  logic [TUSER_IN_W-1:0]  s_axis_tuser = '0;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // key_code[7:0], frame_ready[8], frame_active[9], repeat_total[17:10], zero pad
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned seg_end;
  int unsigned stall_left = 0;
  int          hold_seq = 0;
  int          hold_done = 0;
  logic        idle_on = 1'b0;
  logic [31:0] win_copy [4] = '{32'd52429100, 32'd117966200, 32'd170395800, 32'd308023400};
  logic [7:0]  remote_copy = 8'd0;
  logic [15:0] base;
  int          phase;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nec_ir_pulse_decoder dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nirp_decode_checker decode_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // status receiver with random stalls and one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_done     <= 0;
    end else if (hold_done != hold_seq) begin
      hold_done     <= hold_seq;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left    <= $urandom_range(1, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_width(input logic [2:0] idx);
    int unsigned lo, hi;
    lo = win_copy[idx[1:0]][15:0];
    hi = win_copy[idx[1:0]][31:16];
    if (hi > lo + 1) return 16'($urandom_range(lo + 1, hi - 1));
    return 16'($urandom);
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [15:0] width);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= width;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] zw, ow, rw, hw, input logic [7:0] ra);
    reg_write(REG_ZERO_WIN, zw);
    reg_write(REG_ONE_WIN, ow);
    reg_write(REG_REPEAT_WIN, rw);
    reg_write(REG_HEADER_WIN, hw);
    reg_write(REG_REMOTE, {24'd0, ra});
    win_copy[REG_ZERO_WIN[1:0]]   = zw;
    win_copy[REG_ONE_WIN[1:0]]    = ow;
    win_copy[REG_REPEAT_WIN[1:0]] = rw;
    win_copy[REG_HEADER_WIN[1:0]] = hw;
    remote_copy                   = ra;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) == 0) send_word(2'($urandom), 16'($urandom));
      else send_word(2'($urandom), pick_width(3'($urandom_range(0, 3))));
    end
  endtask

  // header, 32 data bits lsb first, then ticks, scans, repeats and a closing run of ticks, often to a timeout
  task automatic send_frame();
    logic [7:0]  addr, key;
    logic [31:0] code;
    int          i;
    addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : remote_copy;
    key  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
    code = {~key, key, ~addr, addr};
    if ($urandom_range(0, 5) == 0) code[$urandom_range(0, 31)] ^= 1'b1;
    send_word(CMD_RISE, 16'($urandom));
    send_word(CMD_FALL, pick_width(REG_HEADER_WIN));
    for (i = 0; i < 32; i++) begin
      send_word(CMD_RISE, 16'($urandom));
      send_word(CMD_FALL, pick_width(code[i] ? REG_ONE_WIN : REG_ZERO_WIN));
      if ($urandom_range(0, 63) == 0) send_word(2'($urandom), 16'($urandom));
    end
    send_word(CMD_TICK, 16'($urandom));
    send_word(CMD_SCAN, 16'($urandom));
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 4)) send_word(CMD_TICK, 16'($urandom));
      send_word(CMD_RISE, 16'($urandom));
      send_word(CMD_FALL, pick_width(REG_REPEAT_WIN));
      send_word(CMD_SCAN, 16'($urandom));
    end
    repeat (($urandom_range(0, 1) == 0) ? 15 : $urandom_range(0, 16)) begin
      send_word(CMD_TICK, 16'($urandom));
    end
    send_word(CMD_SCAN, 16'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni  <= 1'b1;
    @(posedge clk_i);
    idle_on <= 1'b1;

    // corner cases at reset windows
    send_word(CMD_SCAN, 16'hFFFF);   // scan with nothing ready
    send_word(CMD_TICK, 16'h0000);   // tick outside a frame
    send_word(CMD_FALL, 16'd4500);   // fall without rise
    send_word(CMD_RISE, 16'hFFFF);
    send_word(CMD_FALL, 16'hFFFF);   // width in no window
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_FALL, 16'd4200);   // header minimum, strict compare
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_TICK, 16'h5555);   // tick outside frame keeps the rise
    send_word(CMD_FALL, 16'd4201);   // header opens the frame
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_FALL, 16'h0000);
    send_word(CMD_RISE, 16'hAAAA);
    send_word(CMD_FALL, 16'd799);    // zero bit
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_FALL, 16'd1799);   // one bit
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_FALL, 16'd2201);   // repeat code
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_FALL, 16'd4500);   // header width inside a frame
    send_word(CMD_TICK, 16'h0000);   // frame ready
    send_word(CMD_RISE, 16'h0000);
    send_word(CMD_TICK, 16'h0000);   // tick drops the rise
    send_word(CMD_FALL, 16'd500);
    send_word(CMD_SCAN, 16'h0000);   // check fails and clears
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      base = 16'($urandom_range(0, 4000));
      case (phase)
        0: program_regs(32'd52429100, 32'd117966200, 32'd170395800, 32'd308023400,
                        8'($urandom));
        2: program_regs(32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                        8'hFF);
        3: program_regs({16'd900, 16'd100}, {16'd1200, 16'd500}, {16'd1500, 16'd1100},
                        {16'd4000, 16'd1400}, 8'h00);
        default: program_regs({base + 16'd300, base}, {base + 16'd900, base + 16'd600},
                              {base + 16'd1500, base + 16'd1200},
                              {base + 16'd3000, base + 16'd2000}, 8'($urandom));
      endcase
      if (phase == 1) hold_seq <= hold_seq + 1;
      if (phase == NUM_PHASES - 1) idle_on <= 1'b0;
      seg_end = items_sent + PHASE_ITEMS;
      while (items_sent < seg_end) begin
        if ($urandom_range(0, 3) != 0) send_frame();
        else send_noise();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/nirp_pkg.sv
rtl/nirp_apb_regs.sv
rtl/nirp_in_stage.sv
rtl/nirp_core.sv
rtl/nirp_out_stage.sv
rtl/nec_ir_pulse_decoder.sv
rtl/nirp_checker.sv
test/nirp_decode_checker.sv
test/tb.sv
